FILE: sv/afef_pkg.sv
// ----------------------------------------------------------------------------
// afef_pkg
// Shared types and constants for the audio frame elastic FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package afef_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int FRAME_BITS_DEF = 64;

  localparam int FRAME_W = 64;
  localparam int FILL_W  = 11;
  localparam int SHORT_W = 16;

  localparam logic [SHORT_W-1:0] SHORT_MAX = '1;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [FRAME_W-1:0] frame_in;
    logic               block_last;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               overrun;
    logic               underrun;
    logic [FILL_W-1:0]  fill_level;
    logic [SHORT_W-1:0] block_shortfall;
    logic               block_done;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;     // item accepted, latch result fields
    logic push;     // write frame, advance write pointer
    logic pop;      // read frame, advance read pointer
    logic clear;
    logic overrun;
    logic underrun;
    logic rd_done;  // store read data is valid this cycle
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enable;
    logic empty;
    logic full;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: sv/afef_ram.sv
// ----------------------------------------------------------------------------
// afef_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module afef_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/afef_ctrl.sv
// ----------------------------------------------------------------------------
// afef_ctrl
// Handshake control and opcode decode for the audio frame FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

module afef_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           opcode_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire afef_pkg::dp_status_t status_i,
  output afef_pkg::ctrl_cmd_t       cmd_o
);

  import afef_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   push_req;
  logic   pop_req;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    push_req = 1'b0;
    pop_req  = 1'b0;
    cmd_o    = '0;
    unique case (opcode_i)
      OP_PUSH:  push_req  = accept && status_i.enable;
      OP_POP:   pop_req   = accept && status_i.enable;
      OP_CLEAR: cmd_o.clear = accept;
      default:  ;
    endcase
    cmd_o.load     = accept;
    cmd_o.push     = push_req && !status_i.full;
    cmd_o.overrun  = push_req && status_i.full;
    cmd_o.pop      = pop_req && !status_i.empty;
    cmd_o.underrun = pop_req && status_i.empty;
    cmd_o.rd_done  = (state_q == S_READ);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          // a pop that reads the store waits in S_READ for the registered RAM read
          state_d     = cmd_o.pop ? S_READ : S_IDLE;
          out_valid_d = !cmd_o.pop;
        end else if (out_ready_i) begin
          out_valid_d = 1'b0;
        end
      end
      S_READ: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
      end
      default: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/afef_dp.sv
// ----------------------------------------------------------------------------
// afef_dp
// Pointers, fill and shortfall counters, frame store and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module afef_dp #(
  parameter int DEPTH      = afef_pkg::DEPTH_DEF,
  parameter int FRAME_BITS = afef_pkg::FRAME_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic                 cfg_wdata_i,
  input  wire afef_pkg::in_item_t   in_item_i,
  input  wire afef_pkg::ctrl_cmd_t  cmd_i,
  output afef_pkg::dp_status_t      status_o,
  output afef_pkg::out_item_t       out_item_o
);

  import afef_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);

  logic                  enable_q;
  logic [PW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [PW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [FW-1:0]         fill_q, fill_d;
  logic [SHORT_W-1:0]    short_q, short_d, short_nxt;
  out_item_t             res_q, res_d;
  logic [FRAME_BITS-1:0] rd_data;
  logic [FW+FILL_W-1:0]  fill_ext;
  logic [FRAME_BITS+FRAME_W-1:0] frame_ext;

  assign status_o.enable = enable_q;
  assign status_o.empty  = (fill_q == '0);
  assign status_o.full   = (fill_q == FW'(DEPTH));

  afef_ram #(
    .WIDTH (FRAME_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_item_i.frame_in[FRAME_BITS-1:0]),
    .re_i    (cmd_i.pop),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_data)
  );

  // zero-extend into the fixed-width result fields
  assign fill_ext  = {{FILL_W{1'b0}}, fill_d};
  assign frame_ext = {{FRAME_W{1'b0}}, rd_data};

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (cmd_i.clear) begin
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      fill_d   = '0;
    end else if (cmd_i.push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      fill_d   = fill_q + 1'b1;
    end else if (cmd_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      fill_d   = fill_q - 1'b1;
    end
  end

  always_comb begin
    short_nxt = short_q;
    if ((cmd_i.overrun || cmd_i.underrun) && (short_q != SHORT_MAX)) begin
      short_nxt = short_q + 1'b1;
    end
    short_d = short_q;
    res_d   = res_q;
    if (cmd_i.load) begin
      // count restarts once the last frame of a block has reported it
      short_d               = in_item_i.block_last ? '0 : short_nxt;
      res_d.frame_out       = '0;
      res_d.overrun         = cmd_i.overrun;
      res_d.underrun        = cmd_i.underrun;
      res_d.fill_level      = fill_ext[FILL_W-1:0];
      res_d.block_shortfall = short_nxt;
      res_d.block_done      = in_item_i.block_last;
    end
    if (cmd_i.rd_done) begin
      res_d.frame_out = frame_ext[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
      short_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
      short_q  <= short_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_item_o = res_q;

endmodule

`default_nettype wire

FILE: sv/audio_frame_elastic_fifo.sv
// ----------------------------------------------------------------------------
// audio_frame_elastic_fifo
// Elastic circular frame buffer with overrun/underrun and block shortfall.
// ----------------------------------------------------------------------------
// Every accepted item (push, pop, clear) yields exactly one result. Push,
// clear, no-op and disabled or underrun pops load the result register
// directly; a pop that reads a frame first waits in S_READ for the registered
// read of the frame RAM. A new item is taken when no store read is pending
// and the output register is empty or is being transferred in the same
// cycle, so a pop that reads a frame holds off the next item while its
// store read is pending. The frame store needs no initialization after reset:
// the pointers never read an entry that was not written since reset or clear.
`default_nettype none

module audio_frame_elastic_fifo #(
  parameter int DEPTH      = afef_pkg::DEPTH_DEF,
  parameter int FRAME_BITS = afef_pkg::FRAME_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire afef_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output afef_pkg::out_item_t      out_item_o
);

  import afef_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  afef_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (in_item_i.opcode),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  afef_dp #(
    .DEPTH      (DEPTH),
    .FRAME_BITS (FRAME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

  // a frame read from the store is presented once S_READ has latched it into the result
  a_pop_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> ##2 out_valid_o)
    else $error("popped frame not presented after store read");

  // a waiting result blocks new transfers in
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while result register is occupied");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.overrun && out_item_o.underrun))
    else $error("overrun and underrun on one result");

  a_underrun_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.underrun |-> out_item_o.frame_out == '0)
    else $error("underrun result carries a nonzero frame");

endmodule

`default_nettype wire
